@@ hw/rtl/vbp_pkg.sv @@
`default_nettype none

package vbp_pkg;

  // field widths
  localparam int CODE_W  = 16;
  localparam int WIDTH_W = 5;
  localparam int BYTE_W  = 8;
  localparam int ACC_W   = 24;
  localparam int CNT_W   = 5;
  localparam int S_DATA_W = 24;

  // longest code taken in one request, capped by the code field
  localparam int MAX_CODE_BITS = 16;
  localparam int CODE_LIMIT    = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;

  typedef struct packed {
    logic load;
    logic emit;
  } vbp_cmd_t;

  typedef struct packed {
    logic has_byte;
    logic is_last;
    logic out_free;
  } vbp_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/vbp_ctrl.sv @@
`default_nettype none

module vbp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire vbp_pkg::vbp_sts_t sts,
  output vbp_pkg::vbp_cmd_t     cmd
);
  import vbp_pkg::*;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_EMIT = 1'b1;

  logic [0:0] state;
  logic [0:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts.has_byte) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.is_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/vbp_dp.sv @@
`default_nettype none

module vbp_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [vbp_pkg::CODE_W-1:0]    code_value,
  input  wire logic [vbp_pkg::WIDTH_W-1:0]   code_width,
  input  wire logic                          flush_now,
  input  wire vbp_pkg::vbp_cmd_t             cmd,
  output vbp_pkg::vbp_sts_t                  sts,
  input  wire logic                          m_tready,
  output logic                               m_tvalid,
  output logic [vbp_pkg::BYTE_W-1:0]         out_byte,
  output logic                               last_of_run
);
  import vbp_pkg::*;

  logic [ACC_W-1:0]   acc;
  logic [CNT_W-1:0]   pending;
  logic               flush;

  logic [WIDTH_W-1:0] w_sat;
  logic [CODE_W-1:0]  masked;
  logic [ACC_W-1:0]   acc_app;
  logic [CNT_W-1:0]   pending_app;

  logic               full;
  logic [CNT_W-1:0]   rem;
  logic [CNT_W-1:0]   pad_amt;
  logic [ACC_W-1:0]   acc_sh;
  logic [BYTE_W-1:0]  byte_full;
  logic [BYTE_W-1:0]  byte_pad;
  logic [BYTE_W-1:0]  byte_sel;
  logic [CNT_W-1:0]   pending_emit;
  logic               more;

  // append path
  always_comb begin
    w_sat       = (code_width > WIDTH_W'(CODE_LIMIT)) ? WIDTH_W'(CODE_LIMIT) : code_width;
    masked      = code_value & ~({CODE_W{1'b1}} << w_sat);
    acc_app     = (acc << w_sat) | ACC_W'(masked);
    pending_app = pending + CNT_W'(w_sat);
  end

  // byte extraction, oldest bits first
  always_comb begin
    full      = (pending >= CNT_W'(BYTE_W));
    rem       = pending - CNT_W'(BYTE_W);
    pad_amt   = CNT_W'(BYTE_W) - pending;
    acc_sh    = acc >> rem;
    byte_full = acc_sh[BYTE_W-1:0];
    byte_pad  = acc[BYTE_W-1:0] << pad_amt;
    byte_sel  = full ? byte_full : byte_pad;
    pending_emit = full ? rem : '0;
    more = full && ((pending_emit >= CNT_W'(BYTE_W)) || (flush && (pending_emit != '0)));
  end

  always_comb begin
    sts.has_byte = full || (flush && (pending != '0));
    sts.is_last  = !more;
    sts.out_free = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      pending <= '0;
    end else if (cmd.load) begin
      acc     <= acc_app;
      pending <= pending_app;
    end else if (cmd.emit) begin
      pending <= pending_emit;
      if (!full) begin
        acc <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      flush <= flush_now;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte    <= byte_sel;
      last_of_run <= !more;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/variable_width_bit_packer.sv @@
`default_nettype none

// the idle state loads a request into the accumulator, then the emit state moves its bytes,
// zero to three, to the output register; s_tready is high only in idle, so a new request
// waits for the last one's bytes; a byte waits while m_tready is low and the register is full
// the byte rate is one per cycle while m_tready is high, set by the single byte extractor in the datapath
// reset: synchronous active-high rst empties the accumulator and drops m_tvalid

module variable_width_bit_packer (
  input  wire logic        clk,
  input  wire logic        rst,
  // request side
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [15:0] code_value, [20:16] code_width, [23:21] zero
  input  wire logic        s_tlast,   // flush_now
  // byte side
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] out_byte
  output logic             m_tlast    // last_of_run
);
  import vbp_pkg::*;

  vbp_cmd_t cmd;
  vbp_sts_t sts;

  // controller: idle / emit sequencer
  vbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: accumulator, byte extractor and output register
  vbp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .code_value  (s_tdata[CODE_W-1:0]),
    .code_width  (s_tdata[CODE_W+WIDTH_W-1:CODE_W]),
    .flush_now   (s_tlast),
    .cmd         (cmd),
    .sts         (sts),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .out_byte    (m_tdata),
    .last_of_run (m_tlast)
  );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import vbp_pkg::*;

  // cycles with no handshake on either side before the run is called hung
  localparam int WATCHDOG_LIMIT = 2000;
  // settle time after the last expected byte, to catch stray bytes
  localparam int DRAIN_CYCLES   = 16;

  // one packed byte as it should leave the block
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
  } packed_byte_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;   // [15:0] code_value, [20:16] code_width, [23:21] zero
  logic                s_tlast = 1'b0; // flush_now
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [BYTE_W-1:0]   m_tdata;        // [7:0] out_byte
  logic                m_tlast;        // last_of_run

  // bytes still owed by the block, oldest first
  packed_byte_t expected_bytes[$];

  // shadow of the packer: pending bits right aligned and their count
  int unsigned shadow_acc   = 0;
  int unsigned shadow_count = 0;

  // random idling on both sides, off for the final streaming stretch
  bit idling_on = 1'b1;
  int stall_left = 0;
  int idle_cycles = 0;

  int errors = 0;
  int requests_sent = 0;
  int bytes_checked = 0;
  int flushes_sent = 0;
  int oversize_sent = 0;

  variable_width_bit_packer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // append one code to the shadow accumulator and queue the bytes it frees
  task automatic pack_code(input logic [CODE_W-1:0] value, input logic [WIDTH_W-1:0] width,
                           input logic flush);
    int unsigned  bits;
    int unsigned  mask;
    int           n;
    packed_byte_t freed[3];
    bits = width;
    n = 0;
    // oversize widths saturate at the code limit
    if (bits > CODE_LIMIT) bits = CODE_LIMIT;
    if (bits > 0) begin
      mask = (32'd1 << bits) - 1;
      shadow_acc = ((shadow_acc << bits) | (value & mask)) & 32'hFF_FFFF;
      shadow_count += bits;
    end
    // whole bytes leave from the oldest end
    while (shadow_count >= BYTE_W && n < 3) begin
      freed[n].out_byte = BYTE_W'((shadow_acc >> (shadow_count - BYTE_W)) & 8'hFF);
      freed[n].last_of_run = 1'b0;
      n++;
      shadow_count -= BYTE_W;
      shadow_acc &= (32'd1 << shadow_count) - 1;
    end
    // flush pads a partial byte with zeros below, nothing if already on a boundary
    if (flush && shadow_count > 0 && n < 3) begin
      freed[n].out_byte = BYTE_W'((shadow_acc << (BYTE_W - shadow_count)) & 8'hFF);
      freed[n].last_of_run = 1'b0;
      n++;
      shadow_count = 0;
      shadow_acc = 0;
    end
    if (n > 0) freed[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) expected_bytes.push_back(freed[i]);
  endtask

  // present one request, hold it until the handshake, then predict its bytes
  task automatic send_code(input logic [CODE_W-1:0] value, input logic [WIDTH_W-1:0] width,
                           input logic flush);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, width, value};
    s_tlast  <= flush;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pack_code(value, width, flush);
    requests_sent++;
    if (flush) flushes_sent++;
    if (width > CODE_LIMIT) oversize_sent++;
  endtask

  // mostly legal widths, some zero, some oversize, full width often
  function automatic logic [WIDTH_W-1:0] pick_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 12) return WIDTH_W'($urandom_range(CODE_LIMIT + 1, 31));
    if (r < 30) return WIDTH_W'(CODE_LIMIT);
    return WIDTH_W'($urandom_range(1, CODE_LIMIT - 1));
  endfunction

  // flush on empty, single bit, byte boundary, three bytes from one request
  task automatic test_flush_cases();
    send_code(16'h0000, 5'd0, 1'b1);
    send_code(16'h0001, 5'd1, 1'b1);
    send_code(16'hFFAB, 5'd8, 1'b1);
    send_code(16'h1234, 5'd16, 1'b1);
    send_code(16'hFF7F, 5'd7, 1'b0);
    send_code(16'hFFFF, 5'd16, 1'b1);
    // zero width without flush does nothing at all
    send_code(16'h5555, 5'd0, 1'b0);
  endtask

  // all-ones and all-zero codes at the narrowest and widest widths
  task automatic test_field_extremes();
    send_code(16'hFFFF, 5'd16, 1'b0);
    send_code(16'h0000, 5'd16, 1'b0);
    send_code(16'hFFFF, 5'd1, 1'b0);
    send_code(16'h0000, 5'd15, 1'b0);
    send_code(16'hFFFF, 5'd3, 1'b0);
    send_code(16'h0000, 5'd0, 1'b1);
  endtask

  // widths past the limit take only the low limit bits
  task automatic test_saturation();
    send_code(16'hA5C3, 5'd17, 1'b0);
    send_code(16'hFFFF, 5'd31, 1'b1);
    send_code(16'h0F0F, 5'd24, 1'b1);
    send_code(16'h8001, 5'd5, 1'b0);
    send_code(16'h8001, 5'd16, 1'b1);
  endtask

  // random codes with random idling on both sides
  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++)
      send_code(16'($urandom()), pick_width(), $urandom_range(0, 99) < 12);
  endtask

  // back-to-back requests, both sides always ready
  task automatic test_streaming(input int count);
    idling_on = 1'b0;
    for (int i = 0; i < count; i++)
      send_code(16'($urandom()), pick_width(), $urandom_range(0, 99) < 12);
  endtask

  // byte side: random stall bursts on m_tready while idling is on
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 99) < 15) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // compare every accepted byte with the oldest prediction
  always @(posedge clk) begin
    packed_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte %h last %b", m_tdata, m_tlast);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (m_tdata !== want.out_byte) begin
          $error("out_byte: expected %h, actual %h", want.out_byte, m_tdata);
          errors++;
        end
        if (m_tlast !== want.last_of_run) begin
          $error("last_of_run: expected %b, actual %b", want.last_of_run, m_tlast);
          errors++;
        end
      end
    end
  end

  // watchdog on handshake-free cycles
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d bytes outstanding", expected_bytes.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_flush_cases();
    test_field_extremes();
    test_saturation();
    test_random_mix(300);
    test_streaming(160);
    s_tvalid <= 1'b0;
    // let the block drain, then wait DRAIN_CYCLES more for stray bytes
    while (expected_bytes.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      $error("%0d bytes never arrived", expected_bytes.size());
      errors++;
    end
    $display("covered %0d requests, %0d of them flushes and %0d with oversize widths",
             requests_sent, flushes_sent, oversize_sent);
    $display("checked %0d packed bytes, %0d errors", bytes_checked, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/vbp_pkg.sv
hw/rtl/vbp_ctrl.sv
hw/rtl/vbp_dp.sv
hw/rtl/variable_width_bit_packer.sv
tb/tb.sv
